### sv/ess_pkg.sv
// ----------------------------------------------------------------------------
// Edge symbol splitter package
// Request types, register indexes and the word descriptor shared by the
// front, the word queue and the back of the splitter.
// ----------------------------------------------------------------------------
package ess_pkg;

  // Lengths and indexes are sized for the largest supported word (32 bytes).
  localparam int LEN_W = 6;
  localparam int IDX_W = 5;

  // Configuration register indexes.
  localparam logic REG_MASK_LOW  = 1'b0;
  localparam logic REG_MASK_HIGH = 1'b1;

  localparam logic [7:0] SPACE_CHAR = 8'd32;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       overflow;
  } out_t;

  // One finished word: core is [lo, hi), bytes at or above hi are trailing.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    logic             ovf;
  } desc_t;

  // Front to queue: buffer write and word commit.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;
    logic             commit;
    desc_t            desc;
  } fq_t;

  // Queue to back: oldest finished word and registered buffer read data.
  typedef struct packed {
    logic       avail;
    desc_t      desc;
    logic [7:0] rd_data;
  } qb_t;

  // Back to queue: read index and release of the oldest word.
  typedef struct packed {
    logic [IDX_W-1:0] rd_idx;
    logic             release_word;
  } bq_t;

endpackage

### sv/ess_front.sv
// ----------------------------------------------------------------------------
// Edge symbol splitter front
// Accepts text bytes, classifies them as blank or rigid, collects the word
// into the queue's write slot and commits a descriptor when the word ends.
// ----------------------------------------------------------------------------
module ess_front import ess_pkg::*; #(
  parameter int MAX_WORD = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_t         in_data,
  output logic        in_full,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        q_full,
  output fq_t         fq
);

  localparam int LW = $clog2(MAX_WORD + 1);

  logic [63:0]   mask_lo_r, mask_hi_r;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] lead_r, lead_nxt;
  logic [LW-1:0] trail_r, trail_nxt;
  logic          ovf_r, ovf_nxt;

  logic          accept;
  logic          blank;
  logic          rigid;
  logic          word_end;
  logic [LW-1:0] lo_w;
  logic [LW-1:0] hi_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_lo_r <= '0;
      mask_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASK_LOW:  mask_lo_r <= cfg_data;
        REG_MASK_HIGH: mask_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    blank = in_data.char_code inside {8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
    if (in_data.char_code[7]) begin
      rigid = 1'b0;
    end else if (in_data.char_code[6]) begin
      rigid = mask_hi_r[in_data.char_code[5:0]];
    end else begin
      rigid = mask_lo_r[in_data.char_code[5:0]];
    end
  end

  assign accept   = in_push && !q_full;
  assign word_end = in_data.end_of_text || blank;
  assign in_full  = q_full;

  // A word made only of rigid symbols puts them all in the trailing group.
  assign hi_w = len_r - trail_r;
  assign lo_w = (trail_r == len_r) ? '0 : lead_r;

  always_comb begin
    len_nxt   = len_r;
    lead_nxt  = lead_r;
    trail_nxt = trail_r;
    ovf_nxt   = ovf_r;
    fq        = '0;
    fq.wr_idx  = IDX_W'(len_r);
    fq.wr_data = in_data.char_code;
    fq.desc.len = LEN_W'(len_r);
    fq.desc.lo  = LEN_W'(lo_w);
    fq.desc.hi  = LEN_W'(hi_w);
    fq.desc.ovf = ovf_r;
    if (accept) begin
      if (word_end) begin
        fq.commit = (len_r != '0);
        len_nxt   = '0;
        lead_nxt  = '0;
        trail_nxt = '0;
        ovf_nxt   = 1'b0;
      end else if (len_r < LW'(MAX_WORD)) begin
        fq.wr_en  = 1'b1;
        len_nxt   = len_r + LW'(1);
        trail_nxt = rigid ? trail_r + LW'(1) : '0;
        lead_nxt  = (rigid && lead_r == len_r) ? lead_r + LW'(1) : lead_r;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      lead_r  <= '0;
      trail_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      lead_r  <= lead_nxt;
      trail_r <= trail_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

### sv/ess_wordq.sv
// ----------------------------------------------------------------------------
// Edge symbol splitter word queue
// Two word slots: the front fills the tail slot while the back reads the
// oldest slot. Holds the byte memory and one descriptor per slot.
// ----------------------------------------------------------------------------
module ess_wordq import ess_pkg::*; #(
  parameter int MAX_WORD = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  fq_t  fq,
  input  bq_t  bq,
  output logic q_full,
  output qb_t  qb
);

  localparam int IW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int SLOTS = 2;

  logic [7:0] mem_r [SLOTS][MAX_WORD];
  desc_t      desc_r [SLOTS];
  logic [7:0] rd_data_r;
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (fq.wr_en) begin
      mem_r[tail_r][fq.wr_idx[IW-1:0]] <= fq.wr_data;
    end
    rd_data_r <= mem_r[head_r][bq.rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fq.commit) begin
      desc_r[tail_r] <= fq.desc;
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (fq.commit) begin
      tail_nxt = ~tail_r;
    end
    if (bq.release_word) begin
      head_nxt = ~head_r;
    end
    case ({fq.commit, bq.release_word})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign q_full     = (cnt_r == 2'(SLOTS));
  assign qb.avail   = (cnt_r != '0);
  assign qb.desc    = desc_r[head_r];
  assign qb.rd_data = rd_data_r;

endmodule

### sv/ess_back.sv
// ----------------------------------------------------------------------------
// Edge symbol splitter back
// Walks the oldest finished word byte by byte and writes each byte, and the
// space that follows an edge symbol or the core, into the output register.
// ----------------------------------------------------------------------------
module ess_back import ess_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  qb_t  qb,
  output bq_t  bq,
  input  logic out_pop,
  output logic out_empty,
  output out_t out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHAR  = 2'd2;
  localparam logic [1:0] S_SPACE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             out_vld_r, out_vld_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             load_ok;
  logic             is_final;
  logic             space;

  assign load_ok  = !out_vld_r || out_pop;
  assign is_final = (idx_r + LEN_W'(1) == qb.desc.len);
  assign space    = (idx_r < qb.desc.lo) || (idx_r >= qb.desc.hi) ||
                    (idx_r + LEN_W'(1) == qb.desc.hi);

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    out_vld_nxt     = out_vld_r && !out_pop;
    out_data_nxt    = out_data_r;
    bq.rd_idx       = idx_r[IDX_W-1:0];
    bq.release_word = 1'b0;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (qb.avail) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHAR;
      end
      S_CHAR: begin
        if (load_ok) begin
          out_vld_nxt           = 1'b1;
          out_data_nxt.out_char = qb.rd_data;
          out_data_nxt.last     = !space && is_final;
          out_data_nxt.overflow = qb.desc.ovf;
          if (space) begin
            state_nxt = S_SPACE;
          end else if (is_final) begin
            bq.release_word = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            idx_nxt   = idx_r + LEN_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_SPACE: begin
        if (load_ok) begin
          out_vld_nxt           = 1'b1;
          out_data_nxt.out_char = SPACE_CHAR;
          out_data_nxt.last     = is_final;
          out_data_nxt.overflow = qb.desc.ovf;
          if (is_final) begin
            bq.release_word = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            idx_nxt   = idx_r + LEN_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_empty = !out_vld_r;
  assign out_data  = out_data_r;

endmodule

### sv/edge_symbol_splitter.sv
// ----------------------------------------------------------------------------
// Edge symbol splitter top level
// The front collects words, a two-slot word queue decouples it from the
// back, and the back writes the split text one byte per request.
// ----------------------------------------------------------------------------
// The front accepts one text byte per cycle and holds full only while two
// finished words wait in the queue for the back. Per byte the back passes
// through S_READ and S_CHAR, and S_SPACE too when a space follows the byte,
// and returns to S_IDLE between words; this sequencer and its single buffer
// read port set the output rate. The user must write rigid masks through the
// configuration port only while the block is idle; it does not enforce this.
module edge_symbol_splitter import ess_pkg::*; #(
  parameter int MAX_WORD = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_t         in_data,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  fq_t  fq;
  qb_t  qb;
  bq_t  bq;
  logic q_full;

  ess_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .fq        (fq)
  );

  ess_wordq #(.MAX_WORD(MAX_WORD)) u_wordq (
    .clk    (clk),
    .rst_n  (rst_n),
    .fq     (fq),
    .bq     (bq),
    .q_full (q_full),
    .qb     (qb)
  );

  ess_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qb        (qb),
    .bq        (bq),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
